[sv/motor_feedback_frame_decoder_defines.svh]
// Assertion macros used by the checker of the frame decoder.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_DEFINES_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_DEFINES_SVH

// Check a condition in the same cycle, outside reset.
`define MFFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mffd check failed");

// Check a condition in the cycle after, also across reset.
`define MFFD_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mffd check failed");

`endif

[sv/mffd_pkg.sv]
package mffd_pkg;

   localparam int ID_W     = 11;
   localparam int PAYLOAD_W = 64;
   localparam int ANGLE_W  = 16;
   localparam int WORD_W   = 16;
   localparam int TEMP_W   = 8;
   localparam int TURN_W   = 16;
   localparam int MOTOR_W  = 3;
   localparam int REC_MAX_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ID_FIRST  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ID_SECOND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_THRESHOLD = 2'd2;

   localparam logic [ID_W-1:0]    BASE_ID_RESET = 11'd513;
   localparam logic [WORD_W-1:0]  WRAP_RESET    = 16'd5000;

   localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;
   localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;

   typedef struct packed {
      logic                 matched;
      logic                 bus;
      logic [MOTOR_W-1:0]   motor;
      logic [REC_MAX_W-1:0] rec;
      logic [ANGLE_W-1:0]   angle_now;
      logic [WORD_W-1:0]    speed;
      logic [WORD_W-1:0]    current;
      logic [TEMP_W-1:0]    temp;
   } item_type;

   typedef struct packed {
      logic                     matched;
      logic                     bus;
      logic [MOTOR_W-1:0]       motor;
      logic [ANGLE_W-1:0]       angle_now;
      logic [ANGLE_W-1:0]       angle_before;
      logic [WORD_W-1:0]        speed;
      logic [WORD_W-1:0]        current;
      logic [TEMP_W-1:0]        temp;
      logic signed [TURN_W-1:0] turns;
   } result_type;

endpackage

[sv/mffd_fifo.sv]
module mffd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

[sv/mffd_front.sv]
module mffd_front
   import mffd_pkg::*;
#(
   parameter int MOTORS_PER_BUS = 8
) (
   input  logic                 source_bus,
   input  logic [ID_W-1:0]      frame_id,
   input  logic [PAYLOAD_W-1:0] payload,
   input  logic [ID_W-1:0]      base_id_first,
   input  logic [ID_W-1:0]      base_id_second,
   output item_type             item
);

   localparam logic [ID_W-1:0]      MOTORS_ID  = ID_W'(MOTORS_PER_BUS);
   localparam logic [REC_MAX_W-1:0] MOTORS_REC = REC_MAX_W'(MOTORS_PER_BUS);

   logic [ID_W-1:0] base;
   logic [ID_W-1:0] diff;
   logic            hit;

   always_comb begin
      base = source_bus ? base_id_second : base_id_first;
      diff = frame_id - base;
      hit  = (frame_id >= base) && (diff < MOTORS_ID);

      item           = '0;
      item.matched   = hit;
      item.bus       = source_bus;
      item.motor     = diff[MOTOR_W-1:0];
      item.rec       = source_bus ? REC_MAX_W'(diff) + MOTORS_REC : REC_MAX_W'(diff);
      item.angle_now = payload[63:48];
      item.speed     = payload[47:32];
      item.current   = payload[31:16];
      item.temp      = payload[15:8];
   end

endmodule

[sv/mffd_back.sv]
module mffd_back
   import mffd_pkg::*;
#(
   parameter int MOTORS_PER_BUS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  item_type          item,
   output logic              item_take,
   input  logic              result_room,
   output logic              result_push,
   output result_type        result,
   input  logic [WORD_W-1:0] wrap_threshold
);

   localparam int RECORDS = 2 * MOTORS_PER_BUS;
   localparam int REC_W   = $clog2(RECORDS);

   logic [ANGLE_W-1:0]       angle_ff [RECORDS];
   logic signed [TURN_W-1:0] turn_ff  [RECORDS];

   logic [REC_W-1:0]         rec;
   logic [ANGLE_W-1:0]       angle_prev;
   logic signed [TURN_W-1:0] turns_old;
   logic signed [TURN_W-1:0] turn_in;
   logic signed [ANGLE_W:0]  jump;
   logic signed [ANGLE_W:0]  thr;
   logic                     fire;

   assign fire        = item_valid && result_room;
   assign item_take   = fire;
   assign result_push = fire;

   always_comb begin
      rec        = item.rec[REC_W-1:0];
      angle_prev = angle_ff[rec];
      turns_old  = turn_ff[rec];
      jump       = $signed({1'b0, item.angle_now}) - $signed({1'b0, angle_prev});
      thr        = $signed({1'b0, wrap_threshold});
      turn_in    = turns_old;
      if (jump > thr) begin
         if (turns_old != TURN_MIN) begin
            turn_in = turns_old - 16'sd1;
         end
      end else if (jump < -thr) begin
         if (turns_old != TURN_MAX) begin
            turn_in = turns_old + 16'sd1;
         end
      end

      result = '0;
      if (item.matched) begin
         result.matched      = 1'b1;
         result.bus          = item.bus;
         result.motor        = item.motor;
         result.angle_now    = item.angle_now;
         result.angle_before = angle_prev;
         result.speed        = item.speed;
         result.current      = item.current;
         result.temp         = item.temp;
         result.turns        = turn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RECORDS; i++) begin
            angle_ff[i] <= '0;
            turn_ff[i]  <= '0;
         end
      end else if (fire && item.matched) begin
         angle_ff[rec] <= item.angle_now;
         turn_ff[rec]  <= turn_in;
      end
   end

endmodule

[sv/motor_feedback_frame_decoder.sv]
// Channel  | Handshake          | Carries
// ---------+--------------------+-------------------------------------------------
// req_     | push / full        | source_bus, frame_id, payload
// rsp_     | empty / pop        | matched, reply_bus, motor_index, angles, words,
//          |                    | temperature, turn_count
// csr_     | valid / ready      | index, data (ready always high)
//
// One frame per cycle sustained while rsp_ is popped; a result shows on rsp_ once it has passed
// through the middle queue and the rsp_ queue.
// The record update (read, wrap check, write) is done in the back stage; the write is registered.
// Two-entry queues sit between front and back and ahead of rsp_; each side stalls alone.
// Synchronous reset clears the queues and the motor records and restores the CSR defaults.
module motor_feedback_frame_decoder
   import mffd_pkg::*;
#(
   parameter int MOTORS_PER_BUS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   output logic                     full,
   input  logic                     req_source_bus,
   input  logic [ID_W-1:0]          req_frame_id,
   input  logic [PAYLOAD_W-1:0]     req_payload,
   output logic                     empty,
   input  logic                     pop,
   output logic                     rsp_matched,
   output logic                     rsp_reply_bus,
   output logic [MOTOR_W-1:0]       rsp_motor_index,
   output logic [ANGLE_W-1:0]       rsp_angle_now,
   output logic [ANGLE_W-1:0]       rsp_angle_before,
   output logic [WORD_W-1:0]        rsp_speed_raw,
   output logic [WORD_W-1:0]        rsp_current_raw,
   output logic [TEMP_W-1:0]        rsp_temperature,
   output logic signed [TURN_W-1:0] rsp_turn_count,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data
);

   localparam int ITEM_W   = $bits(item_type);
   localparam int RESULT_W = $bits(result_type);

   logic [ID_W-1:0]   base_first_ff, base_second_ff;
   logic [WORD_W-1:0] wrap_ff;

   item_type          front_item, back_item;
   logic [ITEM_W-1:0] back_bits;
   logic              mid_empty, item_take;
   result_type        back_result, out_result;
   logic [RESULT_W-1:0] out_bits;
   logic              out_full, result_push;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_first_ff  <= BASE_ID_RESET;
         base_second_ff <= BASE_ID_RESET;
         wrap_ff        <= WRAP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BASE_ID_FIRST:  base_first_ff  <= csr_data[ID_W-1:0];
            CSR_BASE_ID_SECOND: base_second_ff <= csr_data[ID_W-1:0];
            CSR_WRAP_THRESHOLD: wrap_ff        <= csr_data;
            default: ;
         endcase
      end
   end

   mffd_front #(.MOTORS_PER_BUS(MOTORS_PER_BUS)) u_front (
      .source_bus     (req_source_bus),
      .frame_id       (req_frame_id),
      .payload        (req_payload),
      .base_id_first  (base_first_ff),
      .base_id_second (base_second_ff),
      .item           (front_item)
   );

   mffd_fifo #(.WIDTH(ITEM_W), .DEPTH(2)) u_mid_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_item),
      .full      (full),
      .pop       (item_take),
      .pop_data  (back_bits),
      .empty     (mid_empty)
   );

   assign back_item = item_type'(back_bits);

   mffd_back #(.MOTORS_PER_BUS(MOTORS_PER_BUS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (!mid_empty),
      .item           (back_item),
      .item_take      (item_take),
      .result_room    (!out_full),
      .result_push    (result_push),
      .result         (back_result),
      .wrap_threshold (wrap_ff)
   );

   mffd_fifo #(.WIDTH(RESULT_W), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (pop),
      .pop_data  (out_bits),
      .empty     (empty)
   );

   assign out_result       = result_type'(out_bits);
   assign rsp_matched      = out_result.matched;
   assign rsp_reply_bus    = out_result.bus;
   assign rsp_motor_index  = out_result.motor;
   assign rsp_angle_now    = out_result.angle_now;
   assign rsp_angle_before = out_result.angle_before;
   assign rsp_speed_raw    = out_result.speed;
   assign rsp_current_raw  = out_result.current;
   assign rsp_temperature  = out_result.temp;
   assign rsp_turn_count   = out_result.turns;

endmodule

[sv/mffd_checker.sv]
`include "motor_feedback_frame_decoder_defines.svh"

module mffd_checker
   import mffd_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     push,
   input logic                     full,
   input logic                     req_source_bus,
   input logic [ID_W-1:0]          req_frame_id,
   input logic [PAYLOAD_W-1:0]     req_payload,
   input logic                     empty,
   input logic                     pop,
   input logic                     rsp_matched,
   input logic                     rsp_reply_bus,
   input logic [MOTOR_W-1:0]       rsp_motor_index,
   input logic [ANGLE_W-1:0]       rsp_angle_now,
   input logic [ANGLE_W-1:0]       rsp_angle_before,
   input logic [WORD_W-1:0]        rsp_speed_raw,
   input logic [WORD_W-1:0]        rsp_current_raw,
   input logic [TEMP_W-1:0]        rsp_temperature,
   input logic signed [TURN_W-1:0] rsp_turn_count,
   input logic                     csr_valid,
   input logic                     csr_ready,
   input logic [CSR_IDX_W-1:0]     csr_index,
   input logic [CSR_DATA_W-1:0]    csr_data
);

   `MFFD_ASSERT_NOW(a_miss_is_zero, clock, reset, !empty && !rsp_matched,
      rsp_reply_bus == 1'b0 && rsp_motor_index == '0 && rsp_angle_now == '0 &&
      rsp_angle_before == '0 && rsp_speed_raw == '0 && rsp_current_raw == '0 &&
      rsp_temperature == '0 && rsp_turn_count == '0)
   `MFFD_ASSERT_NEXT(a_reset_drains, clock, reset, empty && !full)
   `MFFD_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)
   `MFFD_ASSERT_NEXT(a_rsp_hold, clock, !reset && !empty && !pop,
      reset || (!empty && $stable(rsp_turn_count) && $stable(rsp_angle_now)))

endmodule

bind motor_feedback_frame_decoder mffd_checker u_mffd_checker (.*);

[tb/tb_motor_feedback_frame_decoder.sv]
module tb_motor_feedback_frame_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import mffd_pkg::*;

   localparam int MOTORS = 8;
   localparam int RECORDS = 2 * MOTORS;
   localparam int IDLE_LIMIT = 2000;
   localparam int WRAP_REPS = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PERIODIC, RX_STALL} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   logic                     req_source_bus = 1'b0;
   logic [ID_W-1:0]          req_frame_id = '0;
   logic [PAYLOAD_W-1:0]     req_payload = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   logic                     rsp_matched;
   logic                     rsp_reply_bus;
   logic [MOTOR_W-1:0]       rsp_motor_index;
   logic [ANGLE_W-1:0]       rsp_angle_now;
   logic [ANGLE_W-1:0]       rsp_angle_before;
   logic [WORD_W-1:0]        rsp_speed_raw;
   logic [WORD_W-1:0]        rsp_current_raw;
   logic [TEMP_W-1:0]        rsp_temperature;
   logic signed [TURN_W-1:0] rsp_turn_count;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_data = '0;

   // predictor copy of the registers and motor records
   logic [ID_W-1:0]    base_first_cfg = BASE_ID_RESET;
   logic [ID_W-1:0]    base_second_cfg = BASE_ID_RESET;
   logic [WORD_W-1:0]  wrap_limit = WRAP_RESET;
   logic [ANGLE_W-1:0] rec_angle [RECORDS];
   int                 rec_turns [RECORDS];

   result_type  pending_feedback [$];
   int          mismatches = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          rx_left = 0;
   rx_mode_type rx_mode = RX_STREAM;
   bit          rx_steady = 1'b0;
   bit          tx_gaps = 1'b1;

   motor_feedback_frame_decoder #(.MOTORS_PER_BUS(MOTORS)) dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_source_bus   (req_source_bus),
      .req_frame_id     (req_frame_id),
      .req_payload      (req_payload),
      .empty            (empty),
      .pop              (pop),
      .rsp_matched      (rsp_matched),
      .rsp_reply_bus    (rsp_reply_bus),
      .rsp_motor_index  (rsp_motor_index),
      .rsp_angle_now    (rsp_angle_now),
      .rsp_angle_before (rsp_angle_before),
      .rsp_speed_raw    (rsp_speed_raw),
      .rsp_current_raw  (rsp_current_raw),
      .rsp_temperature  (rsp_temperature),
      .rsp_turn_count   (rsp_turn_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic logic [PAYLOAD_W-1:0] make_payload(input logic [ANGLE_W-1:0] angle);
      return {angle, 32'($urandom()), 16'($urandom())};
   endfunction

   task automatic predict_feedback(input logic bus, input logic [ID_W-1:0] id,
                                   input logic [PAYLOAD_W-1:0] pl);
      result_type      want;
      logic [ID_W-1:0] base;
      int              offset;
      int              rec;
      int              jump;
      int              turns;
      want = '0;
      base = bus ? base_second_cfg : base_first_cfg;
      offset = int'(id) - int'(base);
      if (offset >= 0 && offset < MOTORS) begin
         rec = int'(bus) * MOTORS + offset;
         want.matched = 1'b1;
         want.bus = bus;
         want.motor = offset[MOTOR_W-1:0];
         want.angle_now = pl[63:48];
         want.angle_before = rec_angle[rec];
         want.speed = pl[47:32];
         want.current = pl[31:16];
         want.temp = pl[15:8];
         jump = int'(want.angle_now) - int'(want.angle_before);
         turns = rec_turns[rec];
         if (jump > int'(wrap_limit)) begin
            if (turns > int'(TURN_MIN)) turns--;
         end else if (jump < -int'(wrap_limit)) begin
            if (turns < int'(TURN_MAX)) turns++;
         end
         rec_turns[rec] = turns;
         rec_angle[rec] = want.angle_now;
         want.turns = turns[TURN_W-1:0];
      end
      pending_feedback.push_back(want);
   endtask

   task automatic send_frame(input logic bus, input logic [ID_W-1:0] id,
                             input logic [PAYLOAD_W-1:0] pl);
      @(negedge clock);
      push <= 1'b1;
      req_source_bus <= bus;
      req_frame_id <= id;
      req_payload <= pl;
      forever begin
         @(posedge clock);
         if (!full) break;
      end
      predict_feedback(bus, id, pl);
      if (tx_gaps) begin
         if (burst_left == 0) begin
            @(negedge clock);
            push <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(1, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_BASE_ID_FIRST: begin
            base_first_cfg = data[ID_W-1:0];
         end
         CSR_BASE_ID_SECOND: begin
            base_second_cfg = data[ID_W-1:0];
         end
         CSR_WRAP_THRESHOLD: begin
            wrap_limit = data;
         end
         default: begin
         end
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop push and wait for every pending result
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (pending_feedback.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      send_frame(1'b0, 11'd513, {16'h8000, 48'h0123_4567_89AB});
      send_frame(1'b0, 11'd513, {16'h0000, 48'hFEDC_BA98_7600});
      send_frame(1'b0, 11'd520, '1);
      send_frame(1'b0, 11'd520, '0);
      send_frame(1'b0, 11'd512, '1);
      send_frame(1'b0, 11'd521, '1);
      send_frame(1'b0, 11'd0, '1);
      send_frame(1'b0, 11'd2047, '1);
      send_frame(1'b1, 11'd513, {16'hFFFF, 48'h00FF_00FF_00FF});
      send_frame(1'b1, 11'd520, {16'h1234, 48'hFF00_FF00_FF00});
      send_frame(1'b1, 11'd2047, '1);
      send_frame(1'b0, 11'd514, {16'd5000, 48'h0});
      send_frame(1'b0, 11'd514, {16'd10001, 48'h0});
      send_frame(1'b0, 11'd514, {16'd5001, 48'h0});
      send_frame(1'b0, 11'd514, {16'd0, 48'hFFFF_FFFF_FFFF});
   endtask

   task automatic test_register_extremes();
      settle();
      write_csr(CSR_BASE_ID_FIRST, 16'hFFFF);
      write_csr(CSR_BASE_ID_SECOND, 16'hF800);
      write_csr(CSR_WRAP_THRESHOLD, 16'd0);
      write_csr(CSR_UNUSED, 16'h0000);
      send_frame(1'b0, 11'd2047, {16'd0, 48'h0});
      send_frame(1'b0, 11'd2047, {16'd0, 48'h0});
      send_frame(1'b0, 11'd2047, {16'd1, 48'h0});
      send_frame(1'b0, 11'd2047, {16'd0, 48'h0});
      send_frame(1'b0, 11'd2046, '1);
      send_frame(1'b1, 11'd0, '1);
      send_frame(1'b1, 11'd7, '1);
      send_frame(1'b1, 11'd8, '1);
      settle();
      write_csr(CSR_WRAP_THRESHOLD, 16'hFFFF);
      write_csr(CSR_UNUSED, 16'hFFFF);
      send_frame(1'b1, 11'd3, {16'd0, 48'h0});
      send_frame(1'b1, 11'd3, {16'hFFFF, 48'h0});
      send_frame(1'b1, 11'd3, {16'd0, 48'h0});
   endtask

   // three frames per count, one record climbs, one falls
   task automatic test_turn_wraps();
      logic [ANGLE_W-1:0] climb [3];
      logic [ANGLE_W-1:0] fall [3];
      climb = '{16'd0, 16'd32767, 16'd65534};
      fall = '{16'd1, 16'd65535, 16'd32768};
      settle();
      write_csr(CSR_BASE_ID_FIRST, 16'd100);
      write_csr(CSR_BASE_ID_SECOND, 16'd100);
      write_csr(CSR_WRAP_THRESHOLD, 16'd32767);
      rx_steady = 1'b1;
      tx_gaps = 1'b0;
      for (int r = 0; r < WRAP_REPS; r++) begin
         for (int k = 0; k < 3; k++) begin
            send_frame(1'b0, 11'd103, make_payload(climb[k]));
            send_frame(1'b1, 11'd105, make_payload(fall[k]));
         end
      end
      settle();
      rx_steady = 1'b0;
      tx_gaps = 1'b1;
   endtask

   task automatic test_random_traffic();
      logic [ID_W-1:0]    base;
      logic [ID_W-1:0]    id;
      logic [ANGLE_W-1:0] prev;
      logic [ANGLE_W-1:0] angle;
      logic               bus;
      int                 offset;
      int                 span;
      int                 delta;
      for (int phase = 0; phase < 8; phase++) begin
         settle();
         if (phase == 0) begin
            write_csr(CSR_BASE_ID_FIRST, 16'd0);
            write_csr(CSR_BASE_ID_SECOND, 16'd2047);
            write_csr(CSR_WRAP_THRESHOLD, 16'd0);
         end else if (phase == 1) begin
            write_csr(CSR_BASE_ID_FIRST, 16'd2040);
            write_csr(CSR_BASE_ID_SECOND, 16'd2040);
            write_csr(CSR_WRAP_THRESHOLD, 16'hFFFF);
         end else begin
            case ($urandom_range(0, 4))
               0: base = 11'd0;
               1: base = 11'd2047;
               2: base = 11'd2040;
               default: base = 11'($urandom_range(0, 2047));
            endcase
            write_csr(CSR_BASE_ID_FIRST, {5'($urandom()), base});
            if ($urandom_range(0, 1) == 0) base = 11'($urandom_range(0, 2047));
            write_csr(CSR_BASE_ID_SECOND, {5'($urandom()), base});
            case ($urandom_range(0, 3))
               0: write_csr(CSR_WRAP_THRESHOLD, 16'd0);
               1: write_csr(CSR_WRAP_THRESHOLD, 16'($urandom_range(0, 8000)));
               default: write_csr(CSR_WRAP_THRESHOLD, 16'($urandom()));
            endcase
         end
         for (int n = 0; n < 220; n++) begin
            bus = 1'($urandom_range(0, 1));
            base = bus ? base_second_cfg : base_first_cfg;
            case ($urandom_range(0, 9))
               8: id = 11'($urandom_range(0, 2047));
               9: id = ($urandom_range(0, 1) == 0) ? base - 11'd1 : base + 11'd8;
               default: id = base + 11'($urandom_range(0, MOTORS - 1));
            endcase
            offset = int'(id) - int'(base);
            prev = (offset >= 0 && offset < MOTORS) ? rec_angle[int'(bus) * MOTORS + offset]
                                                   : 16'($urandom());
            span = int'(wrap_limit) + 64;
            delta = int'($urandom_range(0, 2 * span)) - span;
            angle = ($urandom_range(0, 9) < 3) ? 16'($urandom()) : prev + delta[ANGLE_W-1:0];
            send_frame(bus, id, make_payload(angle));
         end
      end
   endtask

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      if (rx_steady) begin
         pop <= 1'b1;
      end else begin
         case (rx_mode)
            RX_STREAM: begin
               pop <= 1'b1;
            end
            RX_RANDOM: begin
               pop <= ($urandom_range(0, 2) != 0);
            end
            RX_PERIODIC: begin
               pop <= (rx_left % 4 != 0);
            end
            default: begin
               pop <= 1'b0;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && pop && !empty) begin
         if (pending_feedback.size() == 0) begin
            report_mismatch("transfer with no frame pending", 1, 0);
         end else begin
            want = pending_feedback.pop_front();
            if (rsp_matched !== want.matched)
               report_mismatch("matched", rsp_matched, want.matched);
            if (rsp_reply_bus !== want.bus)
               report_mismatch("reply_bus", rsp_reply_bus, want.bus);
            if (rsp_motor_index !== want.motor)
               report_mismatch("motor_index", rsp_motor_index, want.motor);
            if (rsp_angle_now !== want.angle_now)
               report_mismatch("angle_now", rsp_angle_now, want.angle_now);
            if (rsp_angle_before !== want.angle_before)
               report_mismatch("angle_before", rsp_angle_before, want.angle_before);
            if (rsp_speed_raw !== want.speed)
               report_mismatch("speed_raw", rsp_speed_raw, want.speed);
            if (rsp_current_raw !== want.current)
               report_mismatch("current_raw", rsp_current_raw, want.current);
            if (rsp_temperature !== want.temp)
               report_mismatch("temperature", rsp_temperature, want.temp);
            if (rsp_turn_count !== want.turns)
               report_mismatch("turn_count", rsp_turn_count, want.turns);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int r = 0; r < RECORDS; r++) begin
         rec_angle[r] = '0;
         rec_turns[r] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_turn_wraps();
      test_random_traffic();
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
